@@ hw/rtl/rmfp_pkg.sv @@
// Shared types, constants and parse tables for the route message field parser.
package rmfp_pkg;

    localparam int NAME_BYTES   = 20;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [4:0] CODE_LENGTH  = 5'd0;
    localparam logic [4:0] CODE_COMMAND = 5'd1;
    localparam logic [4:0] CODE_PFX4    = 5'd10;
    localparam logic [4:0] CODE_PFX6_HI = 5'd11;
    localparam logic [4:0] CODE_PFX6_LO = 5'd12;
    localparam logic [4:0] CODE_END     = 5'd25;

    localparam logic [7:0] CMD_IF_ADD     = 8'd1;
    localparam logic [7:0] CMD_IF_DEL     = 8'd2;
    localparam logic [7:0] CMD_ADDR_ADD   = 8'd3;
    localparam logic [7:0] CMD_ADDR_DEL   = 8'd4;
    localparam logic [7:0] CMD_IF_UP      = 8'd5;
    localparam logic [7:0] CMD_IF_DOWN    = 8'd6;
    localparam logic [7:0] CMD_V4_ADD     = 8'd7;
    localparam logic [7:0] CMD_V4_DEL     = 8'd8;
    localparam logic [7:0] CMD_V6_ADD     = 8'd9;
    localparam logic [7:0] CMD_V6_DEL     = 8'd10;
    localparam logic [7:0] CMD_REDIST_ADD = 8'd11;
    localparam logic [7:0] CMD_REDIST_DEL = 8'd12;
    localparam logic [7:0] CMD_NH_LOOKUP  = 8'd15;

    localparam logic [15:0] ADDR_LEN_V4 = 16'd17;
    localparam logic [15:0] ADDR_LEN_V6 = 16'd41;
    localparam logic [15:0] MIN_LEN     = 16'd3;

    typedef enum logic [4:0] {
        PH_LEN_HI   = 5'd0,
        PH_LEN_LO   = 5'd1,
        PH_CMD      = 5'd2,
        PH_IDLE     = 5'd3,
        PH_NAME     = 5'd4,
        PH_IFINDEX  = 5'd5,
        PH_IFFLAGS  = 5'd6,
        PH_IFMETRIC = 5'd7,
        PH_MTU      = 5'd8,
        PH_BW       = 5'd9,
        PH_AIDX     = 5'd10,
        PH_FAMILY   = 5'd11,
        PH_APFX4    = 5'd12,
        PH_APFX6    = 5'd13,
        PH_APLEN    = 5'd14,
        PH_DEST4    = 5'd15,
        PH_DEST6    = 5'd16,
        PH_RTYPE    = 5'd17,
        PH_RFLAGS   = 5'd18,
        PH_RMSG     = 5'd19,
        PH_RPLEN    = 5'd20,
        PH_RPFX     = 5'd21,
        PH_NHNUM    = 5'd22,
        PH_NH4      = 5'd23,
        PH_NH6      = 5'd24,
        PH_IXNUM    = 5'd25,
        PH_IX       = 5'd26,
        PH_DIST     = 5'd27,
        PH_RMETRIC  = 5'd28
    } phase_t;

    typedef struct packed {
        logic [4:0]  code;
        logic [63:0] value;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [1:0] n;
        rec_t       rec1;
        rec_t       rec0;
    } bundle_t;

    function automatic logic [4:0] phase_size(phase_t ph);
        case (ph)
            PH_NAME, PH_FAMILY, PH_APLEN, PH_RTYPE, PH_RFLAGS, PH_RMSG, PH_RPLEN,
            PH_NHNUM, PH_IXNUM, PH_DIST: phase_size = 5'd1;
            PH_IFINDEX, PH_IFFLAGS, PH_IFMETRIC, PH_MTU, PH_BW, PH_AIDX, PH_APFX4,
            PH_DEST4, PH_NH4, PH_IX, PH_RMETRIC: phase_size = 5'd4;
            PH_APFX6, PH_DEST6, PH_NH6: phase_size = 5'd16;
            default: phase_size = 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] phase_code(phase_t ph);
        case (ph)
            PH_NAME:     phase_code = 5'd2;
            PH_IFINDEX:  phase_code = 5'd3;
            PH_IFFLAGS:  phase_code = 5'd4;
            PH_IFMETRIC: phase_code = 5'd5;
            PH_MTU:      phase_code = 5'd6;
            PH_BW:       phase_code = 5'd7;
            PH_AIDX:     phase_code = 5'd3;
            PH_FAMILY:   phase_code = 5'd8;
            PH_APFX4:    phase_code = 5'd10;
            PH_APFX6:    phase_code = 5'd11;
            PH_APLEN:    phase_code = 5'd9;
            PH_DEST4:    phase_code = 5'd13;
            PH_DEST6:    phase_code = 5'd14;
            PH_RTYPE:    phase_code = 5'd16;
            PH_RFLAGS:   phase_code = 5'd17;
            PH_RMSG:     phase_code = 5'd18;
            PH_RPLEN:    phase_code = 5'd9;
            PH_NHNUM:    phase_code = 5'd19;
            PH_NH4:      phase_code = 5'd20;
            PH_NH6:      phase_code = 5'd21;
            PH_IXNUM:    phase_code = 5'd23;
            PH_IX:       phase_code = 5'd3;
            PH_DIST:     phase_code = 5'd24;
            PH_RMETRIC:  phase_code = 5'd5;
            default:     phase_code = 5'd0;
        endcase
    endfunction

    // route sections from s on: 0 nexthops, 1 ifindexes, 2 distance, 3 metric
    function automatic phase_t route_options(logic [3:0] flags, logic [1:0] s);
        if (s == 2'd0 && flags[0]) begin
            route_options = PH_NHNUM;
        end else if (s <= 2'd1 && flags[1]) begin
            route_options = PH_IXNUM;
        end else if (s <= 2'd2 && flags[2]) begin
            route_options = PH_DIST;
        end else if (flags[3]) begin
            route_options = PH_RMETRIC;
        end else begin
            route_options = PH_IDLE;
        end
    endfunction

    function automatic phase_t start_layout(logic [7:0] cmd, logic dir);
        case (cmd)
            CMD_IF_ADD, CMD_IF_UP, CMD_IF_DOWN: start_layout = dir ? PH_IDLE : PH_NAME;
            CMD_IF_DEL: start_layout = PH_NAME;
            CMD_ADDR_ADD, CMD_ADDR_DEL: start_layout = PH_AIDX;
            CMD_V4_ADD, CMD_V4_DEL, CMD_V6_ADD, CMD_V6_DEL, CMD_REDIST_ADD,
            CMD_REDIST_DEL: start_layout = PH_RTYPE;
            CMD_NH_LOOKUP: start_layout = PH_NH4;
            default: start_layout = PH_IDLE;
        endcase
    endfunction

    function automatic bundle_t emit(bundle_t bd, logic [4:0] code, logic [63:0] value);
        bundle_t r;
        r = bd;
        if (bd.n == 2'd0) begin
            r.rec0 = '{code: code, value: value, last: 1'b0};
            r.n = 2'd1;
        end else if (bd.n == 2'd1) begin
            r.rec1 = '{code: code, value: value, last: 1'b0};
            r.n = 2'd2;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/rmfp_parser.sv @@
// Front end: per-byte message parser producing up to two records per byte.
module rmfp_parser
    import rmfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       segment_start,
    input  logic       is_request,
    output bundle_t    bundle
);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  cmd_reg, cmd_next;
    phase_t      phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  flags_reg, flags_next;
    logic [7:0]  rep_reg, rep_next;
    logic        stop_reg, stop_next;
    logic        dir_reg, dir_next;

    always_comb begin
        bundle_t    bd;
        phase_t     ph;
        logic [4:0] size;
        logic [4:0] code;
        logic [5:0] c6;
        logic [7:0] rem;
        logic       done;
        logic       v6;
        logic [7:0] val;
        logic [2:0] sh;
        logic [8:0] plen;
        logic [63:0] shv;

        bd = '0;
        pos_next = pos_reg;
        len_next = len_reg;
        cmd_next = cmd_reg;
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        flags_next = flags_reg;
        rep_next = rep_reg;
        stop_next = stop_reg;
        dir_next = dir_reg;
        size = '0;
        code = '0;
        c6 = '0;
        rem = '0;
        done = 1'b0;
        val = '0;
        sh = '0;
        plen = '0;
        shv = '0;

        if (segment_start) begin
            pos_next = '0; len_next = '0; cmd_next = '0; phase_next = PH_LEN_HI;
            cnt_next = '0; acc_next = '0; flags_next = '0; rep_next = '0;
            stop_next = 1'b0;
            dir_next = is_request;
        end
        ph = phase_next;
        v6 = (cmd_next == CMD_V6_ADD) || (cmd_next == CMD_V6_DEL);

        if (!stop_next) begin
            pos_next = pos_next + 16'd1;
            if (ph == PH_LEN_HI) begin
                len_next = {data_byte, 8'h00};
                phase_next = PH_LEN_LO;
            end else if (ph == PH_LEN_LO) begin
                len_next = {len_next[15:8], data_byte};
                if (len_next < MIN_LEN) begin
                    stop_next = 1'b1;
                    pos_next = '0; len_next = '0; cmd_next = '0; phase_next = PH_LEN_HI;
                    cnt_next = '0; acc_next = '0; flags_next = '0; rep_next = '0;
                end else begin
                    phase_next = PH_CMD;
                end
            end else begin
                if (ph == PH_CMD) begin
                    cmd_next = data_byte;
                    bd = emit(bd, CODE_LENGTH, {48'h0, len_next});
                    bd = emit(bd, CODE_COMMAND, {56'h0, data_byte});
                    acc_next = '0;
                    cnt_next = '0;
                    flags_next = '0;
                    phase_next = start_layout(data_byte, dir_next);
                    rep_next = (phase_next == PH_NAME) ? 8'(NAME_BYTES) : 8'd0;
                end else if (ph == PH_RPFX) begin
                    c6 = cnt_next + 6'd1;
                    rem = rep_next - 8'd1;
                    done = (rem == 8'd0);
                    cnt_next = c6;
                    rep_next = rem;
                    if (!v6) begin
                        if (c6 <= 6'd4) begin
                            acc_next = {acc_next[55:0], data_byte};
                        end
                        if (done) begin
                            sh = (c6 < 6'd4) ? 3'(6'd4 - c6) : 3'd0;
                            shv = {32'h0, acc_next[31:0] << {sh, 3'b000}};
                            bd = emit(bd, CODE_PFX4, shv);
                        end
                    end else begin
                        if (c6 <= 6'd16) begin
                            acc_next = {acc_next[55:0], data_byte};
                        end
                        if (c6 == 6'd8 && !done) begin
                            bd = emit(bd, CODE_PFX6_HI, acc_next);
                            acc_next = '0;
                        end
                        if (done) begin
                            if (c6 <= 6'd8) begin
                                sh = 3'(6'd8 - c6);
                                bd = emit(bd, CODE_PFX6_HI, acc_next << {sh, 3'b000});
                                bd = emit(bd, CODE_PFX6_LO, 64'h0);
                            end else begin
                                sh = (c6 < 6'd16) ? 3'(6'd16 - c6) : 3'd0;
                                bd = emit(bd, CODE_PFX6_LO, acc_next << {sh, 3'b000});
                            end
                        end
                    end
                    if (done) begin
                        acc_next = '0;
                        cnt_next = '0;
                        phase_next = route_options(flags_next, 2'd0);
                    end
                end else begin
                    size = phase_size(ph);
                    code = phase_code(ph);
                    if (size != 5'd0) begin
                        acc_next = {acc_next[55:0], data_byte};
                        c6 = cnt_next + 6'd1;
                        cnt_next = c6;
                        if (size == 5'd16) begin
                            if (c6 == 6'd8) begin
                                bd = emit(bd, code, acc_next);
                                acc_next = '0;
                            end else if (c6 >= 6'd16) begin
                                done = 1'b1;
                                code = code + 5'd1;
                            end
                        end else if (c6 >= {1'b0, size}) begin
                            done = 1'b1;
                        end
                        if (done) begin
                            val = acc_next[7:0];
                            bd = emit(bd, code, acc_next);
                            acc_next = '0;
                            cnt_next = '0;
                            case (ph)
                                PH_NAME: begin
                                    rep_next = rep_next - 8'd1;
                                    phase_next = (rep_next != 8'd0) ? PH_NAME : PH_IFINDEX;
                                end
                                PH_IFINDEX:
                                    phase_next = (cmd_next == CMD_IF_DEL) ? PH_IDLE : PH_IFFLAGS;
                                PH_IFFLAGS:  phase_next = PH_IFMETRIC;
                                PH_IFMETRIC: phase_next = PH_MTU;
                                PH_MTU:      phase_next = PH_BW;
                                PH_AIDX:     phase_next = PH_FAMILY;
                                PH_FAMILY: begin
                                    if (len_next == ADDR_LEN_V4) begin
                                        phase_next = PH_APFX4;
                                    end else if (len_next == ADDR_LEN_V6) begin
                                        phase_next = PH_APFX6;
                                    end else begin
                                        phase_next = PH_IDLE;
                                    end
                                end
                                PH_APFX4, PH_APFX6: phase_next = PH_APLEN;
                                PH_APLEN:
                                    phase_next = (len_next == ADDR_LEN_V4) ? PH_DEST4 : PH_DEST6;
                                PH_RTYPE:
                                    phase_next = (cmd_next == CMD_REDIST_ADD ||
                                                  cmd_next == CMD_REDIST_DEL) ? PH_IDLE
                                                                              : PH_RFLAGS;
                                PH_RFLAGS: phase_next = PH_RMSG;
                                PH_RMSG: begin
                                    flags_next = val[3:0];
                                    phase_next = PH_RPLEN;
                                end
                                PH_RPLEN: begin
                                    plen = {1'b0, val} + 9'd7;
                                    rep_next = {2'b00, plen[8:3]};
                                    phase_next = (rep_next != 8'd0) ? PH_RPFX
                                                                    : route_options(flags_next, 2'd0);
                                end
                                PH_NHNUM: begin
                                    if ({8'h00, val} > len_next) begin
                                        phase_next = PH_IDLE;
                                    end else begin
                                        rep_next = val;
                                        if (val == 8'd0) begin
                                            phase_next = route_options(flags_next, 2'd1);
                                        end else begin
                                            phase_next = v6 ? PH_NH6 : PH_NH4;
                                        end
                                    end
                                end
                                PH_NH4, PH_NH6: begin
                                    if (cmd_next == CMD_NH_LOOKUP) begin
                                        phase_next = PH_RMETRIC;
                                    end else begin
                                        rep_next = rep_next - 8'd1;
                                        phase_next = (rep_next != 8'd0) ? ph
                                                                        : route_options(flags_next, 2'd1);
                                    end
                                end
                                PH_IXNUM: begin
                                    if ({8'h00, val} > len_next) begin
                                        phase_next = PH_IDLE;
                                    end else begin
                                        rep_next = val;
                                        phase_next = (val != 8'd0) ? PH_IX
                                                                   : route_options(flags_next, 2'd2);
                                    end
                                end
                                PH_IX: begin
                                    rep_next = rep_next - 8'd1;
                                    phase_next = (rep_next != 8'd0) ? PH_IX
                                                                    : route_options(flags_next, 2'd2);
                                end
                                PH_DIST: phase_next = route_options(flags_next, 2'd3);
                                default: phase_next = PH_IDLE;
                            endcase
                        end
                    end
                end

                if (pos_next >= len_next) begin
                    if (bd.n == 2'd2) begin
                        bd.rec1.last = 1'b1;
                    end else if (bd.n == 2'd1) begin
                        bd.rec0.last = 1'b1;
                    end else begin
                        bd = emit(bd, CODE_END, 64'h0);
                        bd.rec0.last = 1'b1;
                    end
                    pos_next = '0; len_next = '0; cmd_next = '0; phase_next = PH_LEN_HI;
                    cnt_next = '0; acc_next = '0; flags_next = '0; rep_next = '0;
                end
            end
        end
        bundle = bd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            len_reg <= '0;
            cmd_reg <= '0;
            phase_reg <= PH_LEN_HI;
            cnt_reg <= '0;
            acc_reg <= '0;
            flags_reg <= '0;
            rep_reg <= '0;
            stop_reg <= 1'b0;
            dir_reg <= 1'b0;
        end else if (accept) begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            cmd_reg <= cmd_next;
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
            flags_reg <= flags_next;
            rep_reg <= rep_next;
            stop_reg <= stop_next;
            dir_reg <= dir_next;
        end
    end

endmodule

@@ hw/rtl/rmfp_queue.sv @@
// Short record-bundle queue between the parser and the output stage.
module rmfp_queue
    import rmfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output bundle_t pop_data
);

    bundle_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg;
    logic [QPTR_W-1:0]   rd_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/rmfp_emitter.sv @@
// Back end: unpacks queued bundles into single output words.
module rmfp_emitter
    import rmfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  bundle_t q_data,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output rec_t    out_rec
);

    bundle_t cur_reg;
    logic    valid_reg;
    logic    idx_reg;
    logic    fire;
    logic    final_rec;

    assign fire      = valid_reg && out_ready;
    assign final_rec = idx_reg || (cur_reg.n == 2'd1);
    assign q_pop     = q_valid && (!valid_reg || (fire && final_rec));
    assign out_valid = valid_reg;
    assign out_rec   = idx_reg ? cur_reg.rec1 : cur_reg.rec0;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg <= 1'b0;
        end else if (fire) begin
            if (final_rec) begin
                valid_reg <= 1'b0;
                idx_reg <= 1'b0;
            end else begin
                idx_reg <= 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/route_message_field_parser_core.sv @@
// Top level of the route message field parser.
// Takes one payload byte per cycle and parses it in the same cycle; each byte
// yields zero, one or two field records (two on the command byte and on some
// prefix bytes). Records go through a four-entry bundle queue to an output stage
// that sends one record per cycle while m_tready is high, so input runs at one
// byte per cycle while the output keeps up and stalls only when the queue fills.
module route_message_field_parser_core
    import rmfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [0] segment_start, [1] is_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] field_value
    output logic [4:0]  m_tuser,   // [4:0] field_code
    output logic        m_tlast    // message_end
);

    logic    accept;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    bundle_t bundle;
    bundle_t q_data;
    rec_t    rec;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    rmfp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .data_byte     (s_tdata),
        .segment_start (s_tuser[0]),
        .is_request    (s_tuser[1]),
        .bundle        (bundle)
    );

    rmfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && (bundle.n != 2'd0)),
        .push_data (bundle),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    rmfp_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (rec)
    );

    assign m_tdata = rec.value;
    assign m_tuser = rec.code;
    assign m_tlast = rec.last;

endmodule
